FILE: rtl/iad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_pkg
// Shared constants, the base-set table and a saturating add for the alignment block.
// ----------------------------------------------------------------------------
package iad_pkg;
  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned COST_W      = 11;
  localparam int unsigned PEN_W       = 4;
  localparam int unsigned BASE_W      = 8;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [1:0] OP_APP_FIRST  = 2'd0;
  localparam logic [1:0] OP_APP_SECOND = 2'd1;
  localparam logic [1:0] OP_APP_BOTH   = 2'd2;
  localparam logic [1:0] OP_TRUNC      = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_GROW  = 2'd2;

  localparam logic CFG_GAP      = 1'b0;
  localparam logic CFG_MISMATCH = 1'b1;

  function automatic logic [3:0] base_set(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
    case (u)
      "A":     base_set = 4'd1;
      "C":     base_set = 4'd2;
      "G":     base_set = 4'd4;
      "T":     base_set = 4'd8;
      "U":     base_set = 4'd8;
      "R":     base_set = 4'd5;
      "Y":     base_set = 4'd10;
      "S":     base_set = 4'd6;
      "W":     base_set = 4'd9;
      "K":     base_set = 4'd12;
      "M":     base_set = 4'd3;
      "B":     base_set = 4'd14;
      "D":     base_set = 4'd13;
      "H":     base_set = 4'd11;
      "V":     base_set = 4'd7;
      "N":     base_set = 4'd15;
      default: base_set = 4'd0;
    endcase
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                               input logic [PEN_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - PEN_W){1'b0}}, b};
    sat_add = s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction
endpackage

FILE: rtl/iad_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface iad_in_if #(parameter int unsigned LW = 7);
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  logic [7:0]    first_base;
  logic [7:0]    second_base;
  logic [LW-1:0] new_first_length;
  logic [LW-1:0] new_second_length;
  modport source (output valid, opcode, first_base, second_base,
                  new_first_length, new_second_length, input ready);
  modport sink   (input valid, opcode, first_base, second_base,
                  new_first_length, new_second_length, output ready);
endinterface

interface iad_out_if #(parameter int unsigned LW = 7);
  logic          valid;
  logic          ready;
  logic [10:0]   distance;
  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic [1:0]    status;
  modport source (output valid, distance, first_length, second_length, status,
                  input ready);
  modport sink   (input valid, distance, first_length, second_length, status,
                  output ready);
endinterface

interface iad_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/incremental_alignment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_alignment_distance
// Two growing base strings and their full edit-distance matrix in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one item per operation (append first/second/both, truncate).
//   out_ch  : one result item per input item: distance at both lengths,
//             both lengths and a status.
//   cfg_ch  : register writes (0 gap penalty, 1 mismatch penalty), always
//             ready; write only while idle.
// Operation: items are handled one at a time. The matrix RAM has one read
// port and one write port; each new cell reads one neighbor from RAM and
// keeps the other neighbor and the diagonal in registers, so every cell
// takes a read state and a compute/write state. An append to the first
// string computes row n1, an append to the second computes column n2 and an
// append to both computes both (n1, n2 the new lengths); a truncation or a
// rejected item only reads the final entry before the result is given.
// Reset clears both lengths and sets both penalties to 1. Entry (0,0) reads
// as 0 through an address compare; no clearing pass is needed, as only
// computed cells are read. A stalled receiver holds the result register and
// no new item is taken until it is delivered.
// ----------------------------------------------------------------------------
module incremental_alignment_distance #(
  parameter int unsigned MAX_LEN = iad_pkg::MAX_LEN_DEF,
  parameter int unsigned LW      = $clog2(MAX_LEN + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  iad_in_if.sink   in_ch,
  iad_out_if.source out_ch,
  iad_cfg_if.sink  cfg_ch
);
  import iad_pkg::*;

  localparam int unsigned DIM  = MAX_LEN + 1;
  localparam int unsigned DEP  = DIM * DIM;
  localparam int unsigned AW   = $clog2(DEP);
  localparam int unsigned SW   = $clog2(MAX_LEN);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ROWRD = 7'b0000010,
    S_ROW   = 7'b0000100,
    S_COLRD = 7'b0001000,
    S_COL   = 7'b0010000,
    S_FINRD = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [COST_W-1:0] mat_mem [DEP];
  logic [BASE_W-1:0] s1_mem [MAX_LEN];
  logic [BASE_W-1:0] s2_mem [MAX_LEN];

  logic [LW-1:0] n1_q, n1_d, n2_q, n2_d, k_q, k_d;
  logic [PEN_W-1:0] gap_q, mis_q;
  logic [1:0] op_q, op_d, st_q, st_d;
  logic [COST_W-1:0] left_q, left_d, dist_q;
  logic ovalid_q, ovalid_d;

  logic mwe, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [COST_W-1:0] wdata, rdata_q, diag_q, diag_d, rd_val;

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] i, input logic [LW-1:0] j);
    addr = AW'(i * DIM + j);
  endfunction

  assign in_ch.ready  = (state_q == S_IDLE) && !ovalid_q;
  assign cfg_ch.ready = 1'b1;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // bases for a cell are read in its read cycle
  logic [SW-1:0] s1_pre, s2_pre;
  always_comb begin
    s1_pre = '0; s2_pre = '0;
    if (state_q == S_ROWRD) begin
      s1_pre = SW'(n1_q - 1'b1); s2_pre = SW'(k_q - 1'b1);
    end else if (state_q == S_COLRD) begin
      s1_pre = SW'(k_q - 1'b1); s2_pre = SW'(n2_q - 1'b1);
    end
  end

  // string memories
  logic [BASE_W-1:0] b1p_q, b2p_q;
  always_ff @(posedge clk_i) begin
    if (acc && in_ch.opcode != OP_TRUNC) begin
      if ((in_ch.opcode == OP_APP_FIRST || in_ch.opcode == OP_APP_BOTH)
          && n1_q < LW'(MAX_LEN) && !(in_ch.opcode == OP_APP_BOTH
          && n2_q >= LW'(MAX_LEN)))
        s1_mem[n1_q[SW-1:0]] <= in_ch.first_base;
      if ((in_ch.opcode == OP_APP_SECOND || in_ch.opcode == OP_APP_BOTH)
          && n2_q < LW'(MAX_LEN) && !(in_ch.opcode == OP_APP_BOTH
          && n1_q >= LW'(MAX_LEN)))
        s2_mem[n2_q[SW-1:0]] <= (in_ch.opcode == OP_APP_BOTH) ?
                                in_ch.second_base : in_ch.first_base;
    end
    b1p_q <= s1_mem[s1_pre];
    b2p_q <= s2_mem[s2_pre];
  end

  // matrix memory
  always_ff @(posedge clk_i) begin
    if (mwe) mat_mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mat_mem[raddr];
  end

  // entry (0,0) is never written and reads as 0
  logic zero_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zero_hit_q <= 1'b0;
    else if (rd_en) zero_hit_q <= (raddr == '0);
  end
  assign rd_val = zero_hit_q ? '0 : rdata_q;

  logic [COST_W-1:0] up_v, lf_v, dg_v, mn;
  logic match_p;
  assign match_p = |(base_set(b1p_q) & base_set(b2p_q));

  always_comb begin
    state_d = state_q; n1_d = n1_q; n2_d = n2_q; k_d = k_q; op_d = op_q;
    st_d = st_q; left_d = left_q; diag_d = diag_q; ovalid_d = ovalid_q;
    mwe = 1'b0; waddr = '0; wdata = '0; rd_en = 1'b0; raddr = '0;
    up_v = '0; lf_v = '0; dg_v = '0; mn = '0;
    if (out_ch.valid && out_ch.ready) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          op_d = in_ch.opcode; st_d = ST_DONE; k_d = '0;
          if (in_ch.opcode == OP_TRUNC) begin
            if (in_ch.new_first_length > n1_q || in_ch.new_second_length > n2_q)
              st_d = ST_GROW;
            else begin
              n1_d = in_ch.new_first_length; n2_d = in_ch.new_second_length;
            end
            state_d = S_FINRD;
          end else if (((in_ch.opcode == OP_APP_FIRST || in_ch.opcode == OP_APP_BOTH)
                        && n1_q >= LW'(MAX_LEN)) ||
                       ((in_ch.opcode == OP_APP_SECOND || in_ch.opcode == OP_APP_BOTH)
                        && n2_q >= LW'(MAX_LEN))) begin
            st_d = ST_FULL; state_d = S_FINRD;
          end else begin
            if (in_ch.opcode != OP_APP_SECOND) n1_d = n1_q + 1'b1;
            if (in_ch.opcode != OP_APP_FIRST)  n2_d = n2_q + 1'b1;
            state_d = (in_ch.opcode == OP_APP_SECOND) ? S_COLRD : S_ROWRD;
          end
        end
      end
      // row n1, columns 0..n2 (n2 excluded when append-both; done in column)
      S_ROWRD: begin
        rd_en = 1'b1; raddr = addr(n1_q - 1'b1, k_q);
        state_d = S_ROW;
      end
      S_ROW: begin
        up_v = sat_add(rd_val, gap_q);
        if (k_q == '0) mn = up_v;
        else begin
          lf_v = sat_add(left_q, gap_q);
          dg_v = sat_add(diag_q, match_p ? '0 : mis_q);
          mn = (up_v < lf_v) ? up_v : lf_v;
          if (dg_v < mn) mn = dg_v;
        end
        mwe = 1'b1; waddr = addr(n1_q, k_q); wdata = mn;
        left_d = mn; diag_d = rd_val;
        if (k_q == n2_q || (op_q == OP_APP_BOTH && k_q == n2_q - 1'b1)) begin
          k_d = '0;
          state_d = (op_q == OP_APP_BOTH) ? S_COLRD : S_FINRD;
        end else begin
          k_d = k_q + 1'b1; state_d = S_ROWRD;
        end
      end
      // column n2, rows 0..n1
      S_COLRD: begin
        rd_en = 1'b1; raddr = addr(k_q, n2_q - 1'b1);
        state_d = S_COL;
      end
      S_COL: begin
        lf_v = sat_add(rd_val, gap_q);
        if (k_q == '0) mn = lf_v;
        else begin
          up_v = sat_add(left_q, gap_q);
          dg_v = sat_add(diag_q, match_p ? '0 : mis_q);
          mn = (up_v < lf_v) ? up_v : lf_v;
          if (dg_v < mn) mn = dg_v;
        end
        mwe = 1'b1; waddr = addr(k_q, n2_q); wdata = mn;
        left_d = mn; diag_d = rd_val;
        if (k_q == n1_q) begin
          k_d = '0; state_d = S_FINRD;
        end else begin
          k_d = k_q + 1'b1; state_d = S_COLRD;
        end
      end
      S_FINRD: begin
        rd_en = 1'b1; raddr = addr(n1_q, n2_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) dist_q <= rd_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; n1_q <= '0; n2_q <= '0; k_q <= '0;
      op_q <= OP_APP_FIRST; st_q <= ST_DONE; ovalid_q <= 1'b0;
      gap_q <= 4'd1; mis_q <= 4'd1; left_q <= '0; diag_q <= '0;
    end else begin
      state_q <= state_d; n1_q <= n1_d; n2_q <= n2_d; k_q <= k_d;
      op_q <= op_d; st_q <= st_d; ovalid_q <= ovalid_d;
      left_q <= left_d;
      diag_q <= diag_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_GAP) gap_q <= cfg_ch.data;
        else                         mis_q <= cfg_ch.data;
      end
    end
  end

  assign out_ch.valid         = ovalid_q;
  assign out_ch.distance      = dist_q;
  assign out_ch.first_length  = n1_q;
  assign out_ch.second_length = n2_q;
  assign out_ch.status        = st_q;

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ch.ready |=> ovalid_q && $stable({dist_q, n1_q, n2_q, st_q}))
    else $error("result changed while stalled");

  a_len1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n1_q <= LW'(MAX_LEN)) else $error("first length over capacity");
  a_len2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n2_q <= LW'(MAX_LEN)) else $error("second length over capacity");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == S_IDLE) else $error("busy with result pending");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mwe |-> waddr != '0) else $error("entry zero overwritten");
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for incremental_alignment_distance: drives append and
// truncate items under random idling, predicts each result from its own
// edit-distance matrix, and compares every result field in order.
// ----------------------------------------------------------------------------
module tb;
  import iad_pkg::*;

  localparam int MAXL = 64;
  localparam int DIM = MAXL + 1;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] first_base;
    logic [7:0] second_base;
    logic [6:0] new_first_length;
    logic [6:0] new_second_length;
  } op_item_t;

  typedef struct packed {
    logic [10:0] distance;
    logic [6:0]  first_length;
    logic [6:0]  second_length;
    logic [1:0]  status;
  } dist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iad_in_if  in_ch();
  iad_out_if out_ch();
  iad_cfg_if cfg_ch();

  incremental_alignment_distance dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [10:0] cost_mat [DIM*DIM];
  logic [7:0]  str_a [MAXL];
  logic [7:0]  str_b [MAXL];
  int          len_a, len_b;
  logic [3:0]  gap_pen, mis_pen;

  op_item_t     pending_ops[$];
  dist_result_t expected_results[$];

  int sender_idle_pct, receiver_idle_pct;
  bit receiver_hold;
  int hold_cycles;
  bit hold_request;
  int errors, accepted_in, accepted_out, idle_cycles;
  bit stim_done;

  function automatic logic [12:0] cix(int i, int j);
    return 13'(i * DIM + j);
  endfunction

  function automatic logic [10:0] sat_sum(logic [10:0] a, logic [3:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 2047) ? 11'd2047 : s[10:0];
  endfunction

  function automatic logic [3:0] nuc_set(logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (u)
      "A": return 4'd1;
      "C": return 4'd2;
      "G": return 4'd4;
      "T", "U": return 4'd8;
      "R": return 4'd5;
      "Y": return 4'd10;
      "S": return 4'd6;
      "W": return 4'd9;
      "K": return 4'd12;
      "M": return 4'd3;
      "B": return 4'd14;
      "D": return 4'd13;
      "H": return 4'd11;
      "V": return 4'd7;
      "N": return 4'd15;
      default: return 4'd0;
    endcase
  endfunction

  task automatic compute_cell(int i, int j);
    logic [10:0] v, up, lf, dg;
    if (i == 0 && j == 0) v = '0;
    else if (i == 0) v = sat_sum(cost_mat[cix(0, j-1)], gap_pen);
    else if (j == 0) v = sat_sum(cost_mat[cix(i-1, 0)], gap_pen);
    else begin
      up = sat_sum(cost_mat[cix(i-1, j)], gap_pen);
      lf = sat_sum(cost_mat[cix(i, j-1)], gap_pen);
      dg = sat_sum(cost_mat[cix(i-1, j-1)],
                   (nuc_set(str_a[6'(i-1)]) & nuc_set(str_b[6'(j-1)])) != 4'd0 ?
                   4'd0 : mis_pen);
      v = (up < lf) ? up : lf;
      if (dg < v) v = dg;
    end
    cost_mat[cix(i, j)] = v;
  endtask

  task automatic predict_distance(op_item_t it);
    dist_result_t r;
    bit ga, gb;
    r.status = ST_DONE;
    if (it.opcode == OP_TRUNC) begin
      if (int'(it.new_first_length) > len_a || int'(it.new_second_length) > len_b)
        r.status = ST_GROW;
      else begin
        len_a = int'(it.new_first_length);
        len_b = int'(it.new_second_length);
      end
    end else begin
      ga = (it.opcode == OP_APP_FIRST || it.opcode == OP_APP_BOTH);
      gb = (it.opcode == OP_APP_SECOND || it.opcode == OP_APP_BOTH);
      if ((ga && len_a >= MAXL) || (gb && len_b >= MAXL)) r.status = ST_FULL;
      else begin
        if (ga) begin str_a[6'(len_a)] = it.first_base; len_a++; end
        if (gb) begin
          str_b[6'(len_b)] = (it.opcode == OP_APP_BOTH) ? it.second_base : it.first_base;
          len_b++;
        end
        if (ga) for (int k = 0; k <= len_b; k++) compute_cell(len_a, k);
        if (gb) begin
          for (int k = 0; k <= len_a; k++) compute_cell(k, len_b);
          if (ga) compute_cell(len_a, len_b);
        end
      end
    end
    r.distance = cost_mat[cix(len_a, len_b)];
    r.first_length = len_a[6:0];
    r.second_length = len_b[6:0];
    expected_results.push_back(r);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0;
      in_ch.first_base <= '0;
      in_ch.second_base <= '0;
      in_ch.new_first_length <= '0;
      in_ch.new_second_length <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_distance(pending_ops.pop_front());
        accepted_in++;
      end
      if ((!in_ch.valid || in_ch.ready) && pending_ops.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        in_ch.valid <= 1'b1;
        {in_ch.opcode, in_ch.first_base, in_ch.second_base,
         in_ch.new_first_length, in_ch.new_second_length} <= pending_ops[0];
      end else if (in_ch.valid && in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver and monitor
  always @(posedge clk_i or negedge rst_ni) begin
    dist_result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        accepted_out++;
        got = {out_ch.distance, out_ch.first_length, out_ch.second_length, out_ch.status};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stim_done)
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("timeout");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_base();
    logic [7:0] iupac [32];
    iupac = '{"A","C","G","T","U","R","Y","S","W","K","M","B","D","H","V","N",
              "a","c","g","t","u","r","y","s","w","k","m","b","d","h","v","n"};
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return iupac[5'($urandom_range(31))];
  endfunction

  function automatic op_item_t make_op(logic [1:0] op, logic [7:0] b1, logic [7:0] b2,
                                       int n1, int n2);
    op_item_t it;
    it.opcode = op;
    it.first_base = b1;
    it.second_base = b2;
    it.new_first_length = n1[6:0];
    it.new_second_length = n2[6:0];
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_GAP) gap_pen = val;
    else mis_pen = val;
    @(posedge clk_i);
  endtask

  // random phase; mostly appends, truncates mostly shaped to stay legal
  task automatic queue_random(int count, int sl, int sm);
    int r, la, lb;
    logic [1:0] op;
    la = sl;
    lb = sm;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      op = (r < 30) ? OP_APP_FIRST : (r < 60) ? OP_APP_SECOND : (r < 88) ? OP_APP_BOTH : OP_TRUNC;
      if (op == OP_TRUNC) begin
        if ($urandom_range(5) == 0)
          pending_ops.push_back(make_op(op, 8'($urandom), 8'($urandom), $urandom_range(127),
                                        $urandom_range(127)));
        else begin
          la = ($urandom_range(3) == 0) ? 0 : $urandom_range(la);
          lb = ($urandom_range(3) == 0) ? 0 : $urandom_range(lb);
          pending_ops.push_back(make_op(op, 8'($urandom), 8'($urandom), la, lb));
        end
      end else begin
        pending_ops.push_back(make_op(op, rand_base(), rand_base(), $urandom_range(127),
                                      $urandom_range(127)));
        if (op != OP_APP_SECOND && la < MAXL) la++;
        if (op != OP_APP_FIRST && lb < MAXL) lb++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DIM*DIM; i++) cost_mat[13'(i)] = '0;
    len_a = 0; len_b = 0; gap_pen = 4'd1; mis_pen = 4'd1;
    errors = 0; accepted_in = 0; accepted_out = 0; idle_cycles = 0;
    stim_done = 1'b0; hold_request = 1'b0;
    sender_idle_pct = 14; receiver_idle_pct = 72;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_GAP; cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset penalties, mismatch/iupac, unknown codes, truncate cases
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 1, 0));
    pending_ops.push_back(make_op(OP_APP_FIRST, "A", 0, 0, 0));
    pending_ops.push_back(make_op(OP_APP_SECOND, "a", 0, 0, 0));
    pending_ops.push_back(make_op(OP_APP_BOTH, "R", "g", 0, 0));
    pending_ops.push_back(make_op(OP_APP_BOTH, "-", "-", 0, 0));
    pending_ops.push_back(make_op(OP_APP_BOTH, 8'hff, 8'h00, 127, 127));
    pending_ops.push_back(make_op(OP_APP_BOTH, "U", "t", 0, 0));
    pending_ops.push_back(make_op(OP_APP_BOTH, "N", "x", 0, 0));
    pending_ops.push_back(make_op(OP_APP_SECOND, "Y", 0, 0, 0));
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 5, 6));
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 3, 7));
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 127, 127));
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 2, 1));
    wait_drained();

    write_reg(CFG_GAP, 4'd15);
    write_reg(CFG_MISMATCH, 4'd15);
    pending_ops.push_back(make_op(OP_TRUNC, 0, 0, 0, 0));
    for (int n = 0; n < 66; n++)
      pending_ops.push_back(make_op(OP_APP_BOTH, rand_base(), rand_base(), 0, 0));
    pending_ops.push_back(make_op(OP_APP_FIRST, "C", 0, 0, 0));
    pending_ops.push_back(make_op(OP_APP_SECOND, "C", 0, 0, 0));
    hold_request = 1'b1;
    wait_drained();

    write_reg(CFG_GAP, 4'd0);
    write_reg(CFG_MISMATCH, 4'd7);
    queue_random(550, len_a, len_b);
    wait_drained();

    sender_idle_pct = 72; receiver_idle_pct = 14;
    write_reg(CFG_GAP, 4'd3);
    write_reg(CFG_MISMATCH, 4'd0);
    queue_random(550, len_a, len_b);
    wait_drained();

    sender_idle_pct = 0; receiver_idle_pct = 0;
    write_reg(CFG_GAP, 4'd2);
    write_reg(CFG_MISMATCH, 4'd5);
    queue_random(550, len_a, len_b);
    hold_request = 1'b1;
    wait_drained();
    stim_done = 1'b1;

    $display("covered %0d items, %0d results, gap/mismatch penalties 0..15,", accepted_in,
             accepted_out);
    $display("appends to full strings, legal and growing truncations, IUPAC codes");
    if (errors == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
